// ----- hdl/assert_macros.svh -----
// Assertion helper macros for the frame decoder checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that also holds while reset is asserted.
`define AHWFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Check that is ignored while reset is asserted.
`define AHWFD_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- hdl/ahwfd_pkg.sv -----
// Shared types, constants and decode functions for the frame decoder.
`default_nettype none

package ahwfd_pkg;

    localparam logic [4:0] FRAME_LEN    = 5'd25;
    localparam logic [4:0] POS_LAST     = 5'd24;
    localparam logic [4:0] POS_FZ_FIRST = 5'd9;
    localparam logic [4:0] POS_MX_FIRST = 5'd13;
    localparam logic [4:0] POS_MY_FIRST = 5'd17;
    localparam logic [4:0] POS_MY_END   = 5'd21;

    localparam logic signed [16:0] RAW_CENTER = 17'sd8192;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN_FZ = 3'd0;
    localparam logic [2:0] CFG_GAIN_MX = 3'd1;
    localparam logic [2:0] CFG_GAIN_MY = 3'd2;
    localparam logic [2:0] CFG_BIAS_FZ = 3'd3;
    localparam logic [2:0] CFG_BIAS_MX = 3'd4;
    localparam logic [2:0] CFG_BIAS_MY = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] force_z;
        logic signed [31:0] moment_x;
        logic signed [31:0] moment_y;
        logic [3:0]         tick_digit;
        logic               format_error;
    } t_out_item;

    // One complete reply as handed from the parser to the scaler
    typedef struct packed {
        logic [15:0] raw_fz;
        logic [15:0] raw_mx;
        logic [15:0] raw_my;
        logic [3:0]  tick;
        logic        bad;
    } t_frame;

    typedef struct packed {
        logic [23:0]        gain_fz;
        logic [23:0]        gain_mx;
        logic [23:0]        gain_my;
        logic signed [31:0] bias_fz;
        logic signed [31:0] bias_mx;
        logic signed [31:0] bias_my;
    } t_cfg;

    // {ok, nibble}; a non-hex character gives ok=0 and nibble 0
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Clamp a 35-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v[34:31] != 4'b0000 && v[34:31] != 4'b1111) begin
            r = v[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ahwfd_front.sv -----
// Character parser: position tracking, digit decode and channel accumulation.
`default_nettype none

module ahwfd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire ahwfd_pkg::t_in_item i_item,
    output logic                   o_push,
    output ahwfd_pkg::t_frame      o_frame
);

    logic [4:0]  r_pos, n_pos;
    logic        r_bad, n_bad;
    logic [15:0] r_raw_fz, r_raw_mx, r_raw_my;
    logic [3:0]  r_tick;

    logic [4:0] pos;
    logic       bad_base;
    logic       active;
    logic [4:0] hex;
    logic       tick_ok;
    logic       char_bad;
    logic [3:0] nib;

    always_comb begin
        pos      = i_item.frame_start ? 5'd0 : r_pos;
        bad_base = i_item.frame_start ? 1'b0 : r_bad;
        active   = (pos < ahwfd_pkg::FRAME_LEN);
        hex      = ahwfd_pkg::hex_nibble(i_item.rx_byte);
        tick_ok  = (i_item.rx_byte >= 8'h30) && (i_item.rx_byte <= 8'h39);
        char_bad = (pos == 5'd0) ? !tick_ok : !hex[4];
        nib      = hex[3:0];
        n_pos    = active ? pos + 5'd1 : pos;
        n_bad    = bad_base | (active & char_bad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ahwfd_pkg::FRAME_LEN;
            r_bad <= 1'b0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_bad <= n_bad;
        end
    end

    // Channel payload; every reply rewrites all of it before it is used
    always_ff @(posedge i_clk) begin
        if (i_accept && active) begin
            if (pos == 5'd0) begin
                r_tick <= tick_ok ? i_item.rx_byte[3:0] : 4'd0;
            end else if (pos >= ahwfd_pkg::POS_FZ_FIRST && pos < ahwfd_pkg::POS_MX_FIRST) begin
                r_raw_fz <= {r_raw_fz[11:0], nib};
            end else if (pos >= ahwfd_pkg::POS_MX_FIRST && pos < ahwfd_pkg::POS_MY_FIRST) begin
                r_raw_mx <= {r_raw_mx[11:0], nib};
            end else if (pos >= ahwfd_pkg::POS_MY_FIRST && pos < ahwfd_pkg::POS_MY_END) begin
                r_raw_my <= {r_raw_my[11:0], nib};
            end
        end
    end

    // Last character carries no kept channel, so the raw registers are final
    assign o_push         = i_accept && active && (pos == ahwfd_pkg::POS_LAST);
    assign o_frame.raw_fz = r_raw_fz;
    assign o_frame.raw_mx = r_raw_mx;
    assign o_frame.raw_my = r_raw_my;
    assign o_frame.tick   = r_tick;
    assign o_frame.bad    = n_bad;

endmodule

`default_nettype wire

// ----- hdl/ahwfd_fifo.sv -----
// Small frame queue between parser and scaler.
`default_nettype none

module ahwfd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ahwfd_pkg::t_frame i_frame,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output ahwfd_pkg::t_frame      o_frame
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    ahwfd_pkg::t_frame r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ahwfd_back.sv -----
// Scaler: configuration registers, multiply stage, round/bias/saturate stage.
`default_nettype none

module ahwfd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_frame_valid,
    input  wire ahwfd_pkg::t_frame  i_frame,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output ahwfd_pkg::t_out_item    o_data
);

    ahwfd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ahwfd_pkg::CFG_GAIN_FZ: r_cfg.gain_fz <= i_cfg_data[23:0];
                ahwfd_pkg::CFG_GAIN_MX: r_cfg.gain_mx <= i_cfg_data[23:0];
                ahwfd_pkg::CFG_GAIN_MY: r_cfg.gain_my <= i_cfg_data[23:0];
                ahwfd_pkg::CFG_BIAS_FZ: r_cfg.bias_fz <= i_cfg_data;
                ahwfd_pkg::CFG_BIAS_MX: r_cfg.bias_mx <= i_cfg_data;
                ahwfd_pkg::CFG_BIAS_MY: r_cfg.bias_my <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_v1, r_v2;
    logic en1, en2;
    logic signed [41:0] r_p_fz, r_p_mx, r_p_my;
    logic [3:0] r_tick1;
    logic       r_bad1;

    assign en2   = !r_v2 || !i_stall;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_frame_valid && en1;

    function automatic logic signed [41:0] mul_ch(input logic [15:0] raw,
                                                  input logic [23:0] gain);
        logic signed [16:0] diff;
        diff = $signed({1'b0, raw}) - ahwfd_pkg::RAW_CENTER;
        return diff * $signed({1'b0, gain});
    endfunction

    // Round to nearest (ties up) and bias in one add: bias*256 + 128 is {bias, 0x80}
    function automatic logic signed [31:0] fin_ch(input logic signed [41:0] p,
                                                  input logic signed [31:0] bias);
        logic signed [42:0] sum;
        sum = $signed({p[41], p}) + $signed({{3{bias[31]}}, bias, 8'h80});
        return ahwfd_pkg::sat32(sum[42:8]);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_frame_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_fz  <= mul_ch(i_frame.raw_fz, r_cfg.gain_fz);
            r_p_mx  <= mul_ch(i_frame.raw_mx, r_cfg.gain_mx);
            r_p_my  <= mul_ch(i_frame.raw_my, r_cfg.gain_my);
            r_tick1 <= i_frame.tick;
            r_bad1  <= i_frame.bad;
        end
        if (en2 && r_v1) begin
            o_data.force_z      <= fin_ch(r_p_fz, r_cfg.bias_fz);
            o_data.moment_x     <= fin_ch(r_p_mx, r_cfg.bias_mx);
            o_data.moment_y     <= fin_ch(r_p_my, r_cfg.bias_my);
            o_data.tick_digit   <= r_tick1;
            o_data.format_error <= r_bad1;
        end
    end

    assign o_valid = r_v2;

endmodule

`default_nettype wire

// ----- hdl/ascii_hex_wrench_frame_decoder.sv -----
// Throughput: one character per cycle; the parser takes a byte every cycle unless the
// frame queue is full, and the two-stage scaler (multiply, then round/bias/saturate)
// retires one reply per cycle while i_stall is low. Reset (i_rst_n low, synchronous)
// idles the parser waiting for a start, empties the queue and pipeline and zeroes all
// gains and biases. A reply enters the queue when its 25th character is accepted.
`default_nettype none

module ascii_hex_wrench_frame_decoder #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // character request channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire ahwfd_pkg::t_in_item  i_data,
    // result request channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output ahwfd_pkg::t_out_item      o_data,
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data
);

    logic              accept;
    logic              push;
    ahwfd_pkg::t_frame frame_in;
    ahwfd_pkg::t_frame frame_out;
    logic              q_full;
    logic              q_valid;
    logic              pop;

    // Front side stalls only when the queue cannot take another reply;
    // a stalled scaler output never blocks characters until the queue fills.
    assign o_stall = q_full;
    assign accept  = i_valid && !o_stall;

    ahwfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_push   (push),
        .o_frame  (frame_in)
    );

    ahwfd_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (frame_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_frame (frame_out)
    );

    // Scaler holds the gain/bias registers; the user must make writes only while idle, the block does not enforce it
    ahwfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_frame_valid (q_valid),
        .i_frame       (frame_out),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data)
    );

endmodule

`default_nettype wire

// ----- hdl/ahwfd_checker.sv -----
// Port-level checker for the frame decoder and its bind.
`default_nettype none
`include "assert_macros.svh"

module ahwfd_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_stall,
    input wire ahwfd_pkg::t_out_item o_data,
    input wire logic                 o_valid,
    input wire logic                 i_stall
);

    logic r_in_reset;
    logic reset_exit;
    logic out_wait;
    logic clean_out;

    always_ff @(posedge i_clk) begin
        r_in_reset <= !i_rst_n;
    end

    // First edge after reset is released
    assign reset_exit = i_rst_n && r_in_reset;
    assign out_wait   = o_valid && i_stall;
    assign clean_out  = o_valid && !o_data.format_error;

    `AHWFD_ASSERT_ALWAYS(a_out_idle_after_reset, i_clk, reset_exit |-> !o_valid, "valid after reset")
    `AHWFD_ASSERT_ALWAYS(a_in_open_after_reset, i_clk, reset_exit |-> !o_stall, "stall after reset")
    `AHWFD_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, out_wait |=> o_valid && $stable(o_data), "held result moved")
    `AHWFD_ASSERT_RUN(a_tick_range, i_clk, i_rst_n, clean_out |-> o_data.tick_digit <= 4'd9, "tick above 9")

endmodule

bind ascii_hex_wrench_frame_decoder ahwfd_checker u_ahwfd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_data  (o_data),
    .o_valid (o_valid),
    .i_stall (i_stall)
);

`default_nettype wire

// ----- test/ascii_hex_wrench_frame_decoder_test.sv -----
// Self-checking testbench for the sensor reply decoder: directed replies, then random traffic.
`timescale 1ns / 1ps

module ascii_hex_wrench_frame_decoder_test;

    localparam int          RANDOM_ITEMS  = 750;
    localparam int          QUIET_CYCLES  = 8;      // margin after the last result so the pipe empties
    localparam int          LONG_HOLD     = 300;
    localparam int          RUN_LIMIT_NS  = 3_000_000;
    localparam logic [2:0]  CFG_SPARE_LO  = 3'd6;   // unmapped indexes, must be ignored
    localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;
    localparam logic [7:0]  CH_ZERO       = "0";
    localparam logic [7:0]  CH_NINE       = "9";
    localparam logic [7:0]  CH_UP_A       = "A";
    localparam logic [7:0]  CH_UP_F       = "F";
    localparam logic [7:0]  CH_LO_A       = "a";
    localparam logic [7:0]  CH_LO_F       = "f";
    localparam longint      SAT_HI        = 64'sd2147483647;
    localparam longint      SAT_LO        = -64'sd2147483648;
    localparam logic signed [31:0] PROBE_BIAS = -32'sd163840;   // -2.5 in Q16.16

    typedef enum {SET_KEEP, SET_TOP, SET_BOTTOM, SET_BIAS_ONLY, SET_RANDOM} t_setting;

    // One directed reply: characters, whether the first one carries the start flag,
    // the register setting to load beforehand and, if typed, the result it must give.
    typedef struct {
        string                text;
        bit                   start;
        t_setting             setting;
        bit                   typed;
        ahwfd_pkg::t_out_item want;
    } t_reply_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    ahwfd_pkg::t_in_item  char_data = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    ahwfd_pkg::t_out_item res_data;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_idx = ahwfd_pkg::CFG_GAIN_FZ;
    logic [31:0]          cfg_data = '0;

    // Decoder model state
    logic [4:0]  p_pos = ahwfd_pkg::FRAME_LEN;
    logic [15:0] p_fz = '0;
    logic [15:0] p_mx = '0;
    logic [15:0] p_my = '0;
    logic [3:0]  p_tick = '0;
    logic        p_bad = 1'b0;
    logic [23:0] k_gain_fz = '0;
    logic [23:0] k_gain_mx = '0;
    logic [23:0] k_gain_my = '0;
    logic signed [31:0] k_bias_fz = '0;
    logic signed [31:0] k_bias_mx = '0;
    logic signed [31:0] k_bias_my = '0;

    ahwfd_pkg::t_out_item expected_results[$];
    t_reply_row           reply_table[$];
    int                   mismatches = 0;
    int                   random_items = 0;
    int                   send_gap_max = 3;
    int                   res_stall_max = 3;
    bit                   hold_off_pending = 1'b0;

    ascii_hex_wrench_frame_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (char_valid),
        .o_stall    (char_stall),
        .i_data     (char_data),
        .o_valid    (res_valid),
        .i_stall    (res_stall),
        .o_data     (res_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 4'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = 4'(c - CH_UP_A + 8'd10);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = 4'(c - CH_LO_A + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // (raw - center) * gain is Q.24; round half up into Q16.16, add bias, clamp
    function automatic logic signed [31:0] scale_reading(input logic [15:0] raw,
                                                         input logic [23:0] gain,
                                                         input logic signed [31:0] bias);
        longint prod;
        longint total;
        prod  = (longint'(raw) - longint'(ahwfd_pkg::RAW_CENTER)) * longint'(gain)
                + 64'sd128;
        total = (prod >>> 8) + longint'(bias);
        if (total > SAT_HI) return 32'sh7FFF_FFFF;
        if (total < SAT_LO) return 32'sh8000_0000;
        return total[31:0];
    endfunction

    // Advance the reply parser by one accepted character; returns 1 when a reply completes.
    function automatic bit decode_char(input ahwfd_pkg::t_in_item req,
                                       output ahwfd_pkg::t_out_item res);
        logic [3:0] nib;
        res = '0;
        if (req.frame_start) begin
            p_pos = 5'd0;
            p_bad = 1'b0;
        end
        if (p_pos >= ahwfd_pkg::FRAME_LEN) return 1'b0;     // idle: byte dropped
        if (p_pos == 5'd0) begin
            if (req.rx_byte >= CH_ZERO && req.rx_byte <= CH_NINE) begin
                p_tick = 4'(req.rx_byte - CH_ZERO);
            end else begin
                p_tick = 4'd0;
                p_bad  = 1'b1;
            end
        end else begin
            if (!hex_digit(req.rx_byte, nib)) begin
                nib   = 4'd0;
                p_bad = 1'b1;
            end
            if (p_pos >= ahwfd_pkg::POS_FZ_FIRST && p_pos < ahwfd_pkg::POS_MX_FIRST) begin
                p_fz = {p_fz[11:0], nib};
            end else if (p_pos >= ahwfd_pkg::POS_MX_FIRST
                         && p_pos < ahwfd_pkg::POS_MY_FIRST) begin
                p_mx = {p_mx[11:0], nib};
            end else if (p_pos >= ahwfd_pkg::POS_MY_FIRST
                         && p_pos < ahwfd_pkg::POS_MY_END) begin
                p_my = {p_my[11:0], nib};
            end
        end
        p_pos = p_pos + 5'd1;
        if (p_pos != ahwfd_pkg::FRAME_LEN) return 1'b0;
        res.force_z      = scale_reading(p_fz, k_gain_fz, k_bias_fz);
        res.moment_x     = scale_reading(p_mx, k_gain_mx, k_bias_mx);
        res.moment_y     = scale_reading(p_my, k_gain_my, k_bias_my);
        res.tick_digit   = p_tick;
        res.format_error = p_bad;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_result(input ahwfd_pkg::t_out_item got);
        ahwfd_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("unrequested result, force_z", got.force_z, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.force_z !== want.force_z)
            report_mismatch("force_z", got.force_z, want.force_z);
        if (got.moment_x !== want.moment_x)
            report_mismatch("moment_x", got.moment_x, want.moment_x);
        if (got.moment_y !== want.moment_y)
            report_mismatch("moment_y", got.moment_y, want.moment_y);
        if (got.tick_digit !== want.tick_digit)
            report_mismatch("tick_digit", got.tick_digit, want.tick_digit);
        if (got.format_error !== want.format_error)
            report_mismatch("format_error", got.format_error, want.format_error);
    endtask

    // Inputs are driven by NBA at the edge, so values read here are the pre-edge ones.
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            check_result(res_data);
        end
    end

    // ---------------------------------------------------------------- driving

    // Offer one character request; predict once it is taken.
    task automatic send_char(input logic [7:0] c, input logic start,
                             input bit typed, input ahwfd_pkg::t_out_item want);
        ahwfd_pkg::t_in_item  req;
        ahwfd_pkg::t_out_item got;
        int                   gap;
        req.rx_byte     = c;
        req.frame_start = start;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= req;
        @(posedge clk);
        while (char_stall) @(posedge clk);
        if (decode_char(req, got)) begin
            expected_results.push_back(typed ? want : got);
        end
    endtask

    // Sender pauses until every pending result is back and the pipe has emptied.
    task automatic wait_for_quiet();
        char_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            ahwfd_pkg::CFG_GAIN_FZ: k_gain_fz = data[23:0];
            ahwfd_pkg::CFG_GAIN_MX: k_gain_mx = data[23:0];
            ahwfd_pkg::CFG_GAIN_MY: k_gain_my = data[23:0];
            ahwfd_pkg::CFG_BIAS_FZ: k_bias_fz = data;
            ahwfd_pkg::CFG_BIAS_MX: k_bias_mx = data;
            ahwfd_pkg::CFG_BIAS_MY: k_bias_my = data;
            default: ;
        endcase
    endtask

    function automatic logic [23:0] gain_for(input t_setting s);
        case (s)
            SET_TOP, SET_BOTTOM: return 24'hFF_FFFF;
            SET_BIAS_ONLY:       return 24'd0;
            default: begin
                case ($urandom_range(0, 4))
                    0: return 24'd0;
                    1: return 24'hFF_FFFF;
                    2: return 24'd1 << $urandom_range(0, 23);
                    default: return 24'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] bias_for(input t_setting s);
        case (s)
            SET_TOP:       return 32'h7FFF_FFFF;
            SET_BOTTOM:    return 32'h8000_0000;
            SET_BIAS_ONLY: return PROBE_BIAS;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'd0;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Load all registers while idle; gain writes carry junk above bit 23.
    task automatic apply_setting(input t_setting s);
        if (s == SET_KEEP) return;
        wait_for_quiet();
        write_reg(ahwfd_pkg::CFG_GAIN_FZ, {8'($urandom), gain_for(s)});
        write_reg(ahwfd_pkg::CFG_GAIN_MX, {8'($urandom), gain_for(s)});
        write_reg(ahwfd_pkg::CFG_GAIN_MY, {8'($urandom), gain_for(s)});
        write_reg(ahwfd_pkg::CFG_BIAS_FZ, bias_for(s));
        write_reg(ahwfd_pkg::CFG_BIAS_MX, bias_for(s));
        write_reg(ahwfd_pkg::CFG_BIAS_MY, bias_for(s));
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------- random replies

    function automatic logic [7:0] reply_char(input int pos, input logic [3:0] tick,
                                              input logic [5:0][15:0] chan);
        int         k;
        logic [3:0] nib;
        if (pos == 0) return CH_ZERO + 8'(tick);
        k   = pos - 1;
        nib = chan[k / 4][4 * (3 - k % 4) +: 4];
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(nib) - 8'd10;
    endfunction

    // Any byte that is not legal at this position
    function automatic logic [7:0] junk_char(input bit tick_pos);
        logic [7:0] c;
        logic [3:0] v;
        bit         legal;
        legal = 1'b1;
        c = 8'd0;
        while (legal) begin
            c = 8'($urandom);
            if (tick_pos) legal = (c >= CH_ZERO && c <= CH_NINE);
            else legal = hex_digit(c, v);
        end
        return c;
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h2000;    // exactly at center
            3: return 16'h1FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_pace();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 4;
            default: return 16;
        endcase
    endfunction

    // Mostly clean replies; some with a bad character, some cut short by the
    // next start, and a little line noise between them.
    task automatic random_event();
        logic [5:0][15:0] chan;
        logic [3:0]       tick;
        logic [7:0]       c;
        int               kind, len, bad_at, i;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) begin
                send_char(8'($urandom), 1'b0, 1'b0, '0);
                random_items++;
            end
            return;
        end
        tick = 4'($urandom_range(0, 9));
        for (i = 0; i < 6; i++) chan[i] = pick_raw();
        len    = ahwfd_pkg::FRAME_LEN;
        bad_at = -1;
        if (kind < 18) begin
            len = $urandom_range(1, ahwfd_pkg::FRAME_LEN - 1);
        end else if (kind < 30) begin
            bad_at = $urandom_range(0, ahwfd_pkg::FRAME_LEN - 1);
        end
        for (i = 0; i < len; i++) begin
            c = reply_char(i, tick, chan);
            if (i == bad_at) c = junk_char(i == 0);
            send_char(c, i == 0, 1'b0, '0);
            random_items++;
        end
    endtask

    // ---------------------------------------------------------------- result side

    initial begin : result_sink
        int hold;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever begin
            hold = $urandom_range(0, res_stall_max);
            if (hold_off_pending) begin
                hold = LONG_HOLD;
                hold_off_pending = 1'b0;
            end
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        int n, k, phase, events;
        t_reply_row row;

        // Reset values give zero gain and bias, so these results are all zero.
        reply_table.push_back('{"5a", 1'b0, SET_KEEP, 1'b0, '0});    // idle bytes dropped
        reply_table.push_back('{"9FFFF0000FFFF0000FFFF0000", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd9, 1'b0}});
        reply_table.push_back('{"0abcdef0123456789ABCDEF01", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd0, 1'b0}});
        // bad tick character
        reply_table.push_back('{"X200020002000200020002000", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd0, 1'b1}});
        // bad hex character, reply still emitted
        reply_table.push_back('{"512G420002000200020002000", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd5, 1'b1}});
        // illegal bytes, mostly neighbors of the legal ranges
        reply_table.push_back('{"3/:@G[g002000200020002000", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd3, 1'b1}});
        // start mid-reply: restart drops the partial reply and its error flag
        reply_table.push_back('{"7Z12", 1'b1, SET_KEEP, 1'b0, '0});
        reply_table.push_back('{"4111122223333444455556666", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd4, 1'b0}});
        // trailing bytes after the 25th character are ignored
        reply_table.push_back('{"8200020002000200020002000Q9", 1'b1, SET_KEEP, 1'b1,
                                {32'sd0, 32'sd0, 32'sd0, 4'd8, 1'b0}});
        // full gain and top bias: saturate high
        reply_table.push_back('{"200000000FFFFFFFFFFFF0000", 1'b1, SET_TOP, 1'b1,
                                {32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 4'd2, 1'b0}});
        reply_table.push_back('{"612345678FFFF000020009abc", 1'b1, SET_KEEP, 1'b0, '0});
        // full gain and bottom bias: saturate low
        reply_table.push_back('{"1FFFFFFFF000000000000FFFF", 1'b1, SET_BOTTOM, 1'b1,
                                {32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 4'd1, 1'b0}});
        reply_table.push_back('{"700000000FFFF20001FFF0001", 1'b1, SET_KEEP, 1'b0, '0});
        // zero gain leaves only the bias
        reply_table.push_back('{"0FFFF0000FFFF0000FFFF0000", 1'b1, SET_BIAS_ONLY, 1'b1,
                                {PROBE_BIAS, PROBE_BIAS, PROBE_BIAS, 4'd0, 1'b0}});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < reply_table.size(); n++) begin
            row = reply_table[n];
            apply_setting(row.setting);
            for (k = 0; k < row.text.len(); k++) begin
                send_char(row.text[k], row.start && k == 0, row.typed, row.want);
            end
        end

        // Random phases; each starts from an idle block with fresh registers.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                2: apply_setting(SET_TOP);
                3: apply_setting(SET_BOTTOM);
                default: apply_setting(SET_RANDOM);
            endcase
            send_gap_max  = pick_pace();
            res_stall_max = pick_pace();
            events = 8;
            if (phase == 1) begin
                // sink parks while the source streams: queue fills, input stalls
                send_gap_max     = 0;
                hold_off_pending = 1'b1;
                events           = 14;
            end
            repeat (events) random_event();
            phase++;
        end
        wait_for_quiet();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ahwfd_pkg.sv
hdl/ahwfd_front.sv
hdl/ahwfd_fifo.sv
hdl/ahwfd_back.sv
hdl/ascii_hex_wrench_frame_decoder.sv
hdl/ahwfd_checker.sv
test/ascii_hex_wrench_frame_decoder_test.sv
